/* rtl/deq_pkg.sv */
// Shared types and codes for the double-ended queue.
// Used by deq_front, deq_back and the top level; depends on nothing.
package deq_pkg;

    // Default queue depth and field widths
    localparam int DEQ_DEPTH  = 64;
    localparam int DATA_W     = 32;
    localparam int OPCODE_W   = 3;
    localparam int STATUS_W   = 2;
    localparam int CMDQ_DEPTH = 2;

    // Request opcodes
    localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_DUMP_FWD   = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_DUMP_BWD   = 3'd5;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ELEM  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    // Decoded command
    typedef enum logic [2:0] {
        CMD_PUSH_FRONT,
        CMD_PUSH_BACK,
        CMD_POP_FRONT,
        CMD_POP_BACK,
        CMD_DUMP_FWD,
        CMD_DUMP_BWD
    } t_cmd;

    // One queued request between front and back
    typedef struct packed {
        t_cmd              cmd;
        logic [DATA_W-1:0] value;
    } t_cmd_req;

    // Back-end sequencer states
    typedef enum logic {
        BK_IDLE,
        BK_DUMP
    } t_back_state;

endpackage

/* rtl/double_ended_queue.sv */
// Top level of the bounded double-ended queue of signed 32-bit values.
// Depends on deq_pkg, deq_front, deq_back and deq_ram.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tuser=opcode[2:0], tdata=value[31:0]
//  m_axis    out  m_axis_tvalid/m_axis_tready  tuser=status[1:0], tdata=element[31:0],
//                                              tlast=last
//
// Push and pop are executed without leaving the idle state; with the two-entry command queue
// a request can be taken every cycle while the output is drained.
// A dump first issues a store read, then emits one element per cycle from the single read
// port while the output is not stalled; new commands wait meanwhile.
// Reset clears pointers and count; the store needs no clearing.
// Output stalls hold the result register; the command queue fills behind it.
module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [deq_pkg::DATA_W-1:0]    s_axis_tdata,   // [31:0] value
    input  logic [deq_pkg::OPCODE_W-1:0]  s_axis_tuser,   // [2:0] opcode
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [deq_pkg::DATA_W-1:0]    m_axis_tdata,   // [31:0] element
    output logic [deq_pkg::STATUS_W-1:0]  m_axis_tuser,   // [1:0] status
    output logic                          m_axis_tlast
);
    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic              cmd_valid, cmd_ready;
    t_cmd_req          cmd;
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;

    // Request intake and decode
    deq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_opcode    (s_axis_tuser),
        .i_value     (s_axis_tdata),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    // Execution and result generation
    deq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_status    (m_axis_tuser),
        .o_element   (m_axis_tdata),
        .o_last      (m_axis_tlast)
    );

    // Circular element store
    deq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

/* rtl/deq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/deq_front.sv */
// Front end: accepts requests, decodes the opcode and queues the command.
// Depends on deq_pkg.
module deq_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [deq_pkg::OPCODE_W-1:0]    i_opcode,
    input  logic [deq_pkg::DATA_W-1:0]      i_value,
    output logic                            o_cmd_valid,
    input  logic                            i_cmd_ready,
    output deq_pkg::t_cmd_req               o_cmd
);
    import deq_pkg::*;

    localparam int QW = $clog2(CMDQ_DEPTH);
    localparam int CW = $clog2(CMDQ_DEPTH + 1);

    t_cmd_req          r_q [CMDQ_DEPTH];
    logic [QW-1:0]     r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]     r_cnt;

    logic              op_ok;
    t_cmd              dec_cmd;
    logic              push, pop;

    // Opcode decode; unused codes produce nothing
    always_comb begin
        op_ok   = 1'b1;
        dec_cmd = CMD_PUSH_FRONT;
        unique case (i_opcode)
            OP_PUSH_FRONT: dec_cmd = CMD_PUSH_FRONT;
            OP_PUSH_BACK:  dec_cmd = CMD_PUSH_BACK;
            OP_POP_FRONT:  dec_cmd = CMD_POP_FRONT;
            OP_POP_BACK:   dec_cmd = CMD_POP_BACK;
            OP_DUMP_FWD:   dec_cmd = CMD_DUMP_FWD;
            OP_DUMP_BWD:   dec_cmd = CMD_DUMP_BWD;
            default:       op_ok   = 1'b0;
        endcase
    end

    assign o_ready     = (r_cnt != CW'(CMDQ_DEPTH));
    assign push        = i_valid && o_ready && op_ok;
    assign o_cmd_valid = (r_cnt != '0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rd_ptr];

    // Command queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= '{cmd: dec_cmd, value: i_value};
        end
    end

    // Queue pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

/* rtl/deq_back.sv */
// Back end: holds the queue pointers, executes commands, walks dumps
// and drives the result register. Depends on deq_pkg; drives deq_ram.
module deq_back #(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cmd_valid,
    output logic                            o_cmd_ready,
    input  deq_pkg::t_cmd_req               i_cmd,
    output logic                            o_ram_we,
    output logic [$clog2(DEPTH)-1:0]        o_ram_waddr,
    output logic [deq_pkg::DATA_W-1:0]      o_ram_wdata,
    output logic                            o_ram_re,
    output logic [$clog2(DEPTH)-1:0]        o_ram_raddr,
    input  logic [deq_pkg::DATA_W-1:0]      i_ram_rdata,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [deq_pkg::STATUS_W-1:0]    o_status,
    output logic [deq_pkg::DATA_W-1:0]      o_element,
    output logic                            o_last
);
    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int SW = AW + 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_back_state        r_state, n_state;
    logic [AW-1:0]      r_front, n_front;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_idx, n_idx;
    logic               r_bwd, n_bwd;
    logic               r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [DATA_W-1:0]  r_elem, n_elem;
    logic               r_last, n_last;

    logic               out_free, full, empty, dump_last;
    logic [AW-1:0]      front_dec;

    // Physical slot of an offset from the front, wrapped at DEPTH
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] front,
                                           input logic [AW-1:0] off);
        logic [SW-1:0] s;
        s = {1'b0, front} + {1'b0, off};
        if (s >= SW'(DEPTH)) begin
            s = s - SW'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // Offset of the k-th dumped element for either direction
    function automatic logic [AW-1:0] dump_off(input logic bwd,
                                               input logic [CW-1:0] cnt,
                                               input logic [AW-1:0] k);
        logic [CW-1:0] t;
        t = bwd ? (cnt - CW'(1) - CW'(k)) : CW'(k);
        return t[AW-1:0];
    endfunction

    assign out_free  = !r_out_valid || i_ready;
    assign full      = (r_count == CW'(DEPTH));
    assign empty     = (r_count == '0);
    assign dump_last = ((CW'(r_idx) + CW'(1)) == r_count);
    assign front_dec = (r_front == '0) ? AW'(DEPTH - 1) : (r_front - AW'(1));

    // Command execution and dump sequencing
    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_count     = r_count;
        n_idx       = r_idx;
        n_bwd       = r_bwd;
        n_out_valid = r_out_valid && !i_ready;
        n_status    = r_status;
        n_elem      = r_elem;
        n_last      = r_last;
        o_cmd_ready = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_front;
        o_ram_wdata = i_cmd.value;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_front;

        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_ready = 1'b1;
                    n_out_valid = 1'b1;
                    n_status    = ST_DONE;
                    n_elem      = '0;
                    n_last      = 1'b1;
                    unique case (i_cmd.cmd) inside
                        CMD_PUSH_FRONT: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                o_ram_we    = 1'b1;
                                o_ram_waddr = front_dec;
                                n_front     = front_dec;
                                n_count     = r_count + CW'(1);
                            end
                        end
                        CMD_PUSH_BACK: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                o_ram_we    = 1'b1;
                                o_ram_waddr = slot(r_front, r_count[AW-1:0]);
                                n_count     = r_count + CW'(1);
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_front = slot(r_front, AW'(1));
                                n_count = r_count - CW'(1);
                            end
                        end
                        CMD_POP_BACK: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        CMD_DUMP_FWD, CMD_DUMP_BWD: begin
                            if (empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                // first read goes out now, results follow
                                n_out_valid = 1'b0;
                                n_bwd       = (i_cmd.cmd == CMD_DUMP_BWD);
                                n_idx       = '0;
                                o_ram_re    = 1'b1;
                                o_ram_raddr = slot(r_front,
                                    dump_off(i_cmd.cmd == CMD_DUMP_BWD, r_count, '0));
                                n_state     = BK_DUMP;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b0;
                        end
                    endcase
                end
            end
            BK_DUMP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_ELEM;
                    n_elem      = i_ram_rdata;
                    n_last      = dump_last;
                    if (dump_last) begin
                        n_state = BK_IDLE;
                    end else begin
                        n_idx       = r_idx + AW'(1);
                        o_ram_re    = 1'b1;
                        o_ram_raddr = slot(r_front, dump_off(r_bwd, r_count, n_idx));
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_bwd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_bwd       <= n_bwd;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_elem   <= n_elem;
        r_last   <= n_last;
    end

    assign o_valid   = r_out_valid;
    assign o_status  = r_status;
    assign o_element = r_elem;
    assign o_last    = r_last;

    // Fill count never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count above depth");

    // Dump offset stays inside the held elements
    a_dump_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_DUMP) |-> (CW'(r_idx) < r_count))
        else $error("dump offset past element count");

    // Element field is zero unless an element is emitted
    a_elem_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status != ST_ELEM)) |-> (r_elem == '0))
        else $error("nonzero element on status result");

    // The final dump result returns the sequencer to idle
    a_dump_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == BK_DUMP) && out_free && dump_last) |=> (r_state == BK_IDLE))
        else $error("dump did not end on last element");

    // A successful push grows the queue by one
    a_push_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_ready && i_cmd_valid && !full && ((i_cmd.cmd == CMD_PUSH_FRONT)
         || (i_cmd.cmd == CMD_PUSH_BACK))) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not grow count");

endmodule

/* tb/tb.sv */
// Self-checking testbench for the bounded double-ended queue (double_ended_queue).
// Uses deq_pkg for opcodes and status codes; a shadow deque predicts every reply.
module tb;
    import deq_pkg::*;

    // Opcodes the block must ignore without any reply
    localparam logic [OPCODE_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_7 = 3'd7;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int HOLD_AT_SENT  = 215;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 150;

    typedef struct {
        logic [OPCODE_W-1:0] opcode;
        logic [DATA_W-1:0]   value;
        bit                  wait_idle;   // hold off until all replies are back
    } t_deq_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   element;
        logic                last;
    } t_deq_reply;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                s_axis_tvalid  = 1'b0;
    logic                s_axis_tready;
    logic [DATA_W-1:0]   s_axis_tdata   = '0;   // [31:0] value
    logic [OPCODE_W-1:0] s_axis_tuser   = '0;   // [2:0] opcode
    logic                m_axis_tvalid;
    logic                m_axis_tready  = 1'b0;
    logic [DATA_W-1:0]   m_axis_tdata;          // [31:0] element
    logic [STATUS_W-1:0] m_axis_tuser;          // [1:0] status
    logic                m_axis_tlast;

    t_deq_cmd   cmd_backlog[$];
    t_deq_reply pending_replies[$];
    int         total_cmds;
    int         n_sent          = 0;
    int         mismatch_count  = 0;
    int         cycle_count     = 0;
    int         hold_left       = 0;
    bit         hold_done       = 1'b0;

    // Shadow copy of the queue contents
    logic [DATA_W-1:0] shadow_store [DEQ_DEPTH];
    int                shadow_front = 0;
    int                shadow_count = 0;

    double_ended_queue DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    task automatic add_reply(input logic [STATUS_W-1:0] st, input logic [DATA_W-1:0] elem,
                             input logic lst);
        t_deq_reply r;
        r.status  = st;
        r.element = elem;
        r.last    = lst;
        pending_replies.push_back(r);
    endtask

    // Apply one command to the shadow deque and queue the replies it causes
    task automatic apply_deque_command(input logic [OPCODE_W-1:0] op,
                                       input logic [DATA_W-1:0] val);
        int i;
        int off;
        case (op) inside
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (shadow_count >= DEQ_DEPTH) begin
                    add_reply(ST_FULL, '0, 1'b1);
                end else begin
                    if (op == OP_PUSH_FRONT) begin
                        shadow_front = (shadow_front + DEQ_DEPTH - 1) % DEQ_DEPTH;
                        shadow_store[shadow_front] = val;
                    end else begin
                        shadow_store[(shadow_front + shadow_count) % DEQ_DEPTH] = val;
                    end
                    shadow_count++;
                    add_reply(ST_DONE, '0, 1'b1);
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (shadow_count == 0) begin
                    add_reply(ST_EMPTY, '0, 1'b1);
                end else begin
                    if (op == OP_POP_FRONT)
                        shadow_front = (shadow_front + 1) % DEQ_DEPTH;
                    shadow_count--;
                    add_reply(ST_DONE, '0, 1'b1);
                end
            end
            OP_DUMP_FWD, OP_DUMP_BWD: begin
                if (shadow_count == 0) begin
                    add_reply(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (i = 0; i < shadow_count; i++) begin
                        off = (op == OP_DUMP_FWD) ? i : shadow_count - 1 - i;
                        add_reply(ST_ELEM, shadow_store[(shadow_front + off) % DEQ_DEPTH],
                                  (i + 1 == shadow_count));
                    end
                end
            end
            default: ;  // unused opcodes: no state change, no reply
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("MISMATCH at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    function automatic int sender_idle_pct(input int sent);
        if (sent < 100) return 10;
        if (sent < 200) return 66;
        return 0;
    endfunction

    function automatic int receiver_idle_pct(input int sent);
        if (sent < 100) return 66;
        if (sent < 200) return 10;
        return 0;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Opcode mix: push_pct pushes, pop_pct pops, a few dumps, rare unused codes
    function automatic logic [OPCODE_W-1:0] pick_opcode(input int push_pct, input int pop_pct);
        int r;
        r = $urandom_range(99);
        if (r < push_pct) return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        if (r < push_pct + pop_pct) return $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
        if (r < 97) return $urandom_range(1) ? OP_DUMP_BWD : OP_DUMP_FWD;
        return $urandom_range(1) ? OP_UNUSED_7 : OP_UNUSED_6;
    endfunction

    task automatic queue_cmd(input logic [OPCODE_W-1:0] op, input logic [DATA_W-1:0] val,
                             input bit wait_idle);
        t_deq_cmd c;
        c.opcode    = op;
        c.value     = val;
        c.wait_idle = wait_idle;
        cmd_backlog.push_back(c);
    endtask

    // Request driver: predicts on each accepted request, then offers the next one
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_deque_command(s_axis_tuser, s_axis_tdata);
                n_sent <= n_sent + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (cmd_backlog.size() > 0
                        && !(cmd_backlog[0].wait_idle && pending_replies.size() > 0)
                        && $urandom_range(99) >= sender_idle_pct(n_sent)) begin
                    s_axis_tuser  <= cmd_backlog[0].opcode;
                    s_axis_tdata  <= cmd_backlog[0].value;
                    s_axis_tvalid <= 1'b1;
                    void'(cmd_backlog.pop_front());
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Reply acceptance with random stalls and one long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (hold_left > 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (!hold_done && n_sent >= HOLD_AT_SENT) begin
                hold_done     <= 1'b1;
                hold_left     <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct(n_sent));
            end
        end
    end

    // Reply checker
    always @(posedge i_clk) begin
        t_deq_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_replies.size() == 0) begin
                report_mismatch("unexpected reply, status", DATA_W'(m_axis_tuser), '0);
            end else begin
                want = pending_replies.pop_front();
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", DATA_W'(m_axis_tuser), DATA_W'(want.status));
                if (m_axis_tdata !== want.element)
                    report_mismatch("element", m_axis_tdata, want.element);
                if (m_axis_tlast !== want.last)
                    report_mismatch("last", DATA_W'(m_axis_tlast), DATA_W'(want.last));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int i;
        // Directed: empty cases, unused codes, extreme values, both dump orders
        queue_cmd(OP_DUMP_FWD,   32'h1234_5678, 1'b0);
        queue_cmd(OP_DUMP_BWD,   32'h0,         1'b0);
        queue_cmd(OP_POP_FRONT,  32'hFFFF_FFFF, 1'b0);
        queue_cmd(OP_POP_BACK,   32'h0,         1'b0);
        queue_cmd(OP_UNUSED_6,   32'hDEAD_BEEF, 1'b0);
        queue_cmd(OP_UNUSED_7,   32'h0,         1'b0);
        queue_cmd(OP_PUSH_BACK,  32'h7FFF_FFFF, 1'b0);
        queue_cmd(OP_PUSH_FRONT, 32'h8000_0000, 1'b0);
        queue_cmd(OP_PUSH_BACK,  32'h0000_0000, 1'b0);
        queue_cmd(OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0);
        queue_cmd(OP_DUMP_FWD,   32'h0,         1'b0);
        queue_cmd(OP_DUMP_BWD,   32'h0,         1'b0);
        queue_cmd(OP_POP_FRONT,  32'h0,         1'b0);
        queue_cmd(OP_DUMP_FWD,   32'h0,         1'b0);
        queue_cmd(OP_POP_BACK,   32'h0,         1'b0);
        queue_cmd(OP_DUMP_BWD,   32'h0,         1'b0);
        queue_cmd(OP_POP_FRONT,  32'h0,         1'b0);
        queue_cmd(OP_POP_BACK,   32'h0,         1'b0);
        queue_cmd(OP_POP_BACK,   32'h0,         1'b0);
        queue_cmd(OP_PUSH_FRONT, 32'h5555_5555, 1'b0);
        queue_cmd(OP_PUSH_BACK,  32'hAAAA_AAAA, 1'b0);
        queue_cmd(OP_DUMP_FWD,   32'h0,         1'b0);

        // Random: fill past full, drain past empty, then a mixed stretch
        for (i = 0; i < 90; i++)
            queue_cmd(pick_opcode(90, 4), pick_value(), i == 0);
        for (i = 0; i < 80; i++)
            queue_cmd(pick_opcode(4, 90), pick_value(), i == 40);
        for (i = 0; i < 80; i++)
            queue_cmd(pick_opcode(50, 40), pick_value(), 1'b0);
        total_cmds = cmd_backlog.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_sent < total_cmds) @(posedge i_clk);
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (pending_replies.size() != 0)
            report_mismatch("replies never delivered, count",
                            DATA_W'(pending_replies.size()), '0);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/deq_front.sv
rtl/deq_back.sv
rtl/double_ended_queue.sv
tb/tb.sv
